### hdl/ne_resource_table_indexer_top_macros.svh
// ----------------------------------------------------------------------------
// NE resource table indexer assertion macros
// Shared concurrent assertion wrappers for the indexer checker.
// ----------------------------------------------------------------------------
`ifndef NE_RESOURCE_TABLE_INDEXER_TOP_MACROS_SVH
`define NE_RESOURCE_TABLE_INDEXER_TOP_MACROS_SVH

// property checked at every edge, reset included
`define NRTI_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// property checked outside reset
`define NRTI_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### hdl/nrti_pkg.sv
// ----------------------------------------------------------------------------
// NE resource table indexer package
// Table layout constants, record kinds and the front-to-back job format.
// ----------------------------------------------------------------------------
package nrti_pkg;

   localparam int TABLE_HEADER_BYTES = 2;
   localparam int TYPE_HEADER_BYTES  = 8;
   localparam int NAME_ENTRY_BYTES   = 12;

   localparam int HOLD_DEPTH  = TYPE_HEADER_BYTES - 1;
   localparam int HOLD_IDX_W  = $clog2(HOLD_DEPTH);
   localparam int HOLD_W      = HOLD_DEPTH * 8;
   localparam int HOLD_PAD_W  = (1 << HOLD_IDX_W) * 8;
   localparam int HBI_W       = $clog2(TYPE_HEADER_BYTES);
   localparam int POS_W       = 16;
   localparam int TYPES_W     = 14;
   localparam int NAMES_W     = 16;
   localparam int SKIP_W      = 16 + $clog2(NAME_ENTRY_BYTES + 1);
   localparam int SCAN_W      = $clog2(HOLD_DEPTH + 257);
   localparam int RESCAN_CAP  = 5;
   localparam int FOUND_W     = $clog2(RESCAN_CAP + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [TYPES_W-1:0] TYPES_MAX = '1;
   localparam logic [NAMES_W-1:0] NAMES_MAX = '1;

   typedef enum logic [1:0] {
      KIND_TYPE    = 2'd0,
      KIND_NAME    = 2'd1,
      KIND_SUMMARY = 2'd2
   } nrti_kind_type;

   typedef struct packed {
      logic                has_rec;
      nrti_kind_type       rec_kind;
      logic [POS_W-1:0]    offset;
      logic [15:0]         type_code;
      logic [15:0]         count;
      logic                is_end;
      logic [HBI_W-1:0]    scan_len;
      logic [POS_W-1:0]    scan_start;
      logic [HOLD_W-1:0]   held;
   } nrti_job_type;

endpackage

### hdl/nrti_if.sv
// ----------------------------------------------------------------------------
// NE resource table indexer channels
// Valid/ready interfaces for the byte input and the record output.
// ----------------------------------------------------------------------------
interface nrti_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface nrti_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  record_kind;
   logic [15:0] entry_offset;
   logic [15:0] type_code;
   logic [15:0] resource_total;
   logic [13:0] type_entries_found;
   logic [15:0] names_found;
   logic        final_result;

   modport source (output valid, record_kind, entry_offset, type_code, resource_total,
                   type_entries_found, names_found, final_result, input ready);
   modport sink   (input valid, record_kind, entry_offset, type_code, resource_total,
                   type_entries_found, names_found, final_result, output ready);
endinterface

### hdl/nrti_front.sv
// ----------------------------------------------------------------------------
// NE resource table indexer front end
// Walks bytes one per cycle while the job queue has room; queues record jobs.
// ----------------------------------------------------------------------------
module nrti_front (
   input  logic                 clock,
   input  logic                 reset,
   nrti_req_if.sink             req_chan,
   output logic                 push,
   output nrti_pkg::nrti_job_type push_job,
   input  logic                 queue_full
);

   typedef enum logic [4:0] {
      SEC_HEADER    = 5'b00001,
      SEC_TYPE      = 5'b00010,
      SEC_TYPE_SKIP = 5'b00100,
      SEC_NAMES     = 5'b01000,
      SEC_DONE      = 5'b10000
   } sec_type;

   sec_type                           sec_ff, sec_in;
   logic [nrti_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [nrti_pkg::HBI_W-1:0]        hbi_ff, hbi_in;
   logic [15:0]                       tid_ff, tid_in;
   logic [15:0]                       cnt_ff, cnt_in;
   logic [nrti_pkg::SKIP_W-1:0]       skip_ff, skip_in;
   logic [7:0]                        held_ff [nrti_pkg::HOLD_DEPTH];

   logic                              accept;
   logic [7:0]                        b;
   logic [nrti_pkg::HBI_W:0]          n;
   logic [15:0]                       tid_now;
   logic [15:0]                       cnt_now;
   logic [nrti_pkg::SKIP_W-1:0]       skip_calc;
   logic                              held_we;
   logic [nrti_pkg::HOLD_W-1:0]       held_merged;
   logic                              rec_valid;
   nrti_pkg::nrti_kind_type           rec_kind;
   logic [nrti_pkg::POS_W-1:0]        rec_offset;
   logic                              scan;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.data_byte;
   assign n              = {1'b0, hbi_ff} + 1'b1;
   assign held_we        = accept && (sec_ff == SEC_TYPE) &&
                           (hbi_ff < nrti_pkg::HBI_W'(nrti_pkg::HOLD_DEPTH));

   always_comb begin
      tid_now = tid_ff;
      cnt_now = cnt_ff;
      if (n == (nrti_pkg::HBI_W+1)'(1)) begin
         tid_now = {8'h00, b};
      end else if (n == (nrti_pkg::HBI_W+1)'(2)) begin
         tid_now = {b, tid_ff[7:0]};
      end else if (n == (nrti_pkg::HBI_W+1)'(3)) begin
         cnt_now = {8'h00, b};
      end else if (n == (nrti_pkg::HBI_W+1)'(4)) begin
         cnt_now = {b, cnt_ff[7:0]};
      end
   end

   assign skip_calc = nrti_pkg::SKIP_W'(cnt_now) *
                      nrti_pkg::SKIP_W'(nrti_pkg::NAME_ENTRY_BYTES);

   always_comb begin
      for (int j = 0; j < nrti_pkg::HOLD_DEPTH; j++) begin
         held_merged[j*8 +: 8] = (held_we && hbi_ff == nrti_pkg::HBI_W'(j)) ? b : held_ff[j];
      end
   end

   always_comb begin
      sec_in     = sec_ff;
      pos_in     = pos_ff;
      hbi_in     = hbi_ff;
      tid_in     = tid_ff;
      cnt_in     = cnt_ff;
      skip_in    = skip_ff;
      rec_valid  = 1'b0;
      rec_kind   = nrti_pkg::KIND_TYPE;
      rec_offset = pos_ff;
      scan       = 1'b0;
      push_job   = '0;

      if (accept) begin
         unique case (sec_ff)
            SEC_HEADER: begin
               if ({1'b0, pos_ff} + 17'd1 >= 17'(nrti_pkg::TABLE_HEADER_BYTES)) begin
                  sec_in = SEC_TYPE;
                  hbi_in = '0;
               end
            end
            SEC_TYPE: begin
               tid_in = tid_now;
               cnt_in = cnt_now;
               hbi_in = n[nrti_pkg::HBI_W-1:0];
               if (n == (nrti_pkg::HBI_W+1)'(2) && tid_now == 16'h0000) begin
                  sec_in  = SEC_NAMES;
                  skip_in = '0;
                  hbi_in  = '0;
               end else if (n == (nrti_pkg::HBI_W+1)'(nrti_pkg::TYPE_HEADER_BYTES)) begin
                  rec_valid  = 1'b1;
                  rec_kind   = nrti_pkg::KIND_TYPE;
                  rec_offset = pos_ff - nrti_pkg::POS_W'(nrti_pkg::TYPE_HEADER_BYTES - 1);
                  skip_in    = skip_calc;
                  sec_in     = (skip_calc != '0) ? SEC_TYPE_SKIP : SEC_TYPE;
                  hbi_in     = '0;
               end
            end
            SEC_TYPE_SKIP: begin
               if (skip_ff != '0) begin
                  skip_in = skip_ff - 1'b1;
               end
               if (skip_ff <= nrti_pkg::SKIP_W'(1)) begin
                  sec_in = SEC_TYPE;
               end
            end
            SEC_NAMES: begin
               if (skip_ff != '0) begin
                  skip_in = skip_ff - 1'b1;
               end else if (b == 8'h00) begin
                  sec_in = SEC_DONE;
               end else begin
                  rec_valid  = 1'b1;
                  rec_kind   = nrti_pkg::KIND_NAME;
                  rec_offset = pos_ff;
                  skip_in    = nrti_pkg::SKIP_W'(b);
               end
            end
            SEC_DONE: begin
            end
            default: begin
            end
         endcase

         pos_in = pos_ff + 1'b1;

         push_job.has_rec   = rec_valid;
         push_job.rec_kind  = rec_kind;
         push_job.offset    = rec_offset;
         push_job.type_code = (rec_kind == nrti_pkg::KIND_TYPE) ? tid_now : 16'h0000;
         push_job.count     = (rec_kind == nrti_pkg::KIND_TYPE) ? cnt_now : 16'h0000;
         push_job.held      = held_merged;

         if (req_chan.last_byte) begin
            scan                = (sec_in == SEC_TYPE) && (hbi_in != '0);
            push_job.is_end     = 1'b1;
            push_job.scan_len   = scan ? hbi_in : '0;
            push_job.scan_start = pos_ff - (nrti_pkg::POS_W'(hbi_in) - 16'd1);
            sec_in  = SEC_HEADER;
            pos_in  = '0;
            hbi_in  = '0;
            tid_in  = '0;
            cnt_in  = '0;
            skip_in = '0;
         end
      end
   end

   assign push = accept && (rec_valid || req_chan.last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff  <= SEC_HEADER;
         pos_ff  <= '0;
         hbi_ff  <= '0;
         tid_ff  <= '0;
         cnt_ff  <= '0;
         skip_ff <= '0;
      end else begin
         sec_ff  <= sec_in;
         pos_ff  <= pos_in;
         hbi_ff  <= hbi_in;
         tid_ff  <= tid_in;
         cnt_ff  <= cnt_in;
         skip_ff <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (held_we) begin
         held_ff[hbi_ff[nrti_pkg::HOLD_IDX_W-1:0]] <= b;
      end
   end

endmodule

### hdl/nrti_queue.sv
// ----------------------------------------------------------------------------
// NE resource table indexer job queue
// Short FIFO of record jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module nrti_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  nrti_pkg::nrti_job_type push_job,
   output logic                   full,
   input  logic                   pop,
   output nrti_pkg::nrti_job_type pop_job,
   output logic                   empty
);

   nrti_pkg::nrti_job_type        entry_ff [nrti_pkg::QUEUE_DEPTH];
   logic [nrti_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [nrti_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [nrti_pkg::QPTR_W:0]     count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign full    = (count_ff == (nrti_pkg::QPTR_W+1)'(nrti_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### hdl/nrti_back.sv
// ----------------------------------------------------------------------------
// NE resource table indexer back end
// Emits queued records, rescans truncated type headers, closes each table.
// ----------------------------------------------------------------------------
module nrti_back (
   input  logic                   clock,
   input  logic                   reset,
   input  nrti_pkg::nrti_job_type job,
   input  logic                   empty,
   output logic                   pop,
   nrti_rsp_if.source             rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_SCAN    = 3'b010,
      ST_SUMMARY = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [nrti_pkg::TYPES_W-1:0]       types_ff, types_in;
   logic [nrti_pkg::NAMES_W-1:0]       names_ff, names_in;
   logic [nrti_pkg::HOLD_W-1:0]        scan_held_ff, scan_held_in;
   logic [nrti_pkg::HBI_W-1:0]         scan_len_ff, scan_len_in;
   logic [nrti_pkg::POS_W-1:0]         scan_start_ff, scan_start_in;
   logic [nrti_pkg::SCAN_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [nrti_pkg::FOUND_W-1:0]       found_ff, found_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   nrti_pkg::nrti_kind_type            kind_ff;
   logic [15:0]                        offset_ff;
   logic [15:0]                        tcode_ff;
   logic [15:0]                        rtot_ff;
   logic [nrti_pkg::TYPES_W-1:0]       otypes_ff;
   logic [nrti_pkg::NAMES_W-1:0]       onames_ff;
   logic                               final_ff;

   logic                               out_free;
   logic                               emit;
   nrti_pkg::nrti_kind_type            e_kind;
   logic [15:0]                        e_offset;
   logic [15:0]                        e_tcode;
   logic [15:0]                        e_rtot;
   logic [nrti_pkg::TYPES_W-1:0]       e_types;
   logic [nrti_pkg::NAMES_W-1:0]       e_names;
   logic                               e_final;
   logic [nrti_pkg::HOLD_PAD_W-1:0]    scan_pad;
   logic [7:0]                         cur_len;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign scan_pad = nrti_pkg::HOLD_PAD_W'(scan_held_ff);
   assign cur_len  = scan_pad[scan_idx_ff[nrti_pkg::HOLD_IDX_W-1:0]*8 +: 8];

   always_comb begin
      state_in      = state_ff;
      types_in      = types_ff;
      names_in      = names_ff;
      scan_held_in  = scan_held_ff;
      scan_len_in   = scan_len_ff;
      scan_start_in = scan_start_ff;
      scan_idx_in   = scan_idx_ff;
      found_in      = found_ff;
      pop           = 1'b0;
      emit          = 1'b0;
      e_kind        = nrti_pkg::KIND_NAME;
      e_offset      = '0;
      e_tcode       = '0;
      e_rtot        = '0;
      e_types       = '0;
      e_names       = '0;
      e_final       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (out_free && !empty) begin
               pop = 1'b1;
               if (job.has_rec) begin
                  emit     = 1'b1;
                  e_kind   = job.rec_kind;
                  e_offset = job.offset;
                  e_tcode  = job.type_code;
                  e_rtot   = job.count;
                  if (job.rec_kind == nrti_pkg::KIND_TYPE) begin
                     if (types_ff != nrti_pkg::TYPES_MAX) types_in = types_ff + 1'b1;
                  end else begin
                     if (names_ff != nrti_pkg::NAMES_MAX) names_in = names_ff + 1'b1;
                  end
               end
               if (job.is_end) begin
                  scan_held_in  = job.held;
                  scan_len_in   = job.scan_len;
                  scan_start_in = job.scan_start;
                  scan_idx_in   = '0;
                  found_in      = '0;
                  state_in      = (job.scan_len != '0) ? ST_SCAN : ST_SUMMARY;
               end
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               if (scan_idx_ff < nrti_pkg::SCAN_W'(scan_len_ff) &&
                   found_ff < nrti_pkg::FOUND_W'(nrti_pkg::RESCAN_CAP) &&
                   cur_len != 8'h00) begin
                  emit        = 1'b1;
                  e_kind      = nrti_pkg::KIND_NAME;
                  e_offset    = scan_start_ff + nrti_pkg::POS_W'(scan_idx_ff);
                  scan_idx_in = scan_idx_ff + nrti_pkg::SCAN_W'(cur_len) + 1'b1;
                  found_in    = found_ff + 1'b1;
                  if (names_ff != nrti_pkg::NAMES_MAX) names_in = names_ff + 1'b1;
               end else begin
                  state_in = ST_SUMMARY;
               end
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               emit     = 1'b1;
               e_kind   = nrti_pkg::KIND_SUMMARY;
               e_types  = types_ff;
               e_names  = names_ff;
               e_final  = 1'b1;
               types_in = '0;
               names_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         types_ff     <= '0;
         names_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         types_ff     <= types_in;
         names_ff     <= names_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_held_ff  <= scan_held_in;
      scan_len_ff   <= scan_len_in;
      scan_start_ff <= scan_start_in;
      scan_idx_ff   <= scan_idx_in;
      found_ff      <= found_in;
      if (emit) begin
         kind_ff   <= e_kind;
         offset_ff <= e_offset;
         tcode_ff  <= e_tcode;
         rtot_ff   <= e_rtot;
         otypes_ff <= e_types;
         onames_ff <= e_names;
         final_ff  <= e_final;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.record_kind        = kind_ff;
   assign rsp_chan.entry_offset       = offset_ff;
   assign rsp_chan.type_code          = tcode_ff;
   assign rsp_chan.resource_total     = rtot_ff;
   assign rsp_chan.type_entries_found = otypes_ff;
   assign rsp_chan.names_found        = onames_ff;
   assign rsp_chan.final_result       = final_ff;

endmodule

### hdl/ne_resource_table_indexer_top.sv
// ----------------------------------------------------------------------------
// NE resource table indexer
// Indexes type entries and resource names of an NE resource table stream.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan takes one table byte per transfer; last_byte closes the table.
//  rsp_chan gives records: type entries (offset, id, count), name entries
//  (offset of the length byte) and one summary record per table carrying
//  both counts with final_result set. A new table may follow at once.
//  Throughput: one byte per cycle while the queue has room. A byte
//  that causes a record queues a job; the back end pops it into the
//  output register that drives rsp_chan.
//  The back end emits one record per cycle while rsp_chan is not stalled;
//  at the end of a table that stops inside a type header it rescans the
//  held bytes, one name per cycle (up to five), then ends the scan and
//  emits the summary.
//  A four-entry job queue sits between the byte walker and the record
//  emitter; req_chan.ready drops only while that queue is full, so a
//  stalled receiver backs up the queue first, then the input.
//  Reset (synchronous, active high) clears the walker, the queue, the
//  counts and any pending record.
// ----------------------------------------------------------------------------
module ne_resource_table_indexer_top (
   input  logic        clock,
   input  logic        reset,
   nrti_req_if.sink    req_chan,
   nrti_rsp_if.source  rsp_chan
);

   logic                   push;
   nrti_pkg::nrti_job_type push_job;
   logic                   queue_full;
   logic                   pop;
   nrti_pkg::nrti_job_type pop_job;
   logic                   queue_empty;

   nrti_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   nrti_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   nrti_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job      (pop_job),
      .empty    (queue_empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### hdl/nrti_checker.sv
// ----------------------------------------------------------------------------
// NE resource table indexer checker
// Port-level assertions on the record channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "ne_resource_table_indexer_top_macros.svh"

module nrti_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_offset,
   input logic [15:0] rsp_tcode,
   input logic [15:0] rsp_rtot,
   input logic [13:0] rsp_types,
   input logic [15:0] rsp_names,
   input logic        rsp_final
);

   logic [80:0] rsp_payload;
   logic        rsp_stall;
   logic        summary_ok;
   logic        entry_ok;

   assign rsp_payload = {rsp_kind, rsp_offset, rsp_tcode, rsp_rtot,
                         rsp_types, rsp_names, rsp_final};
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign summary_ok  = (rsp_kind == nrti_pkg::KIND_SUMMARY) && (rsp_offset == 16'h0000) &&
                        (rsp_tcode == 16'h0000) && (rsp_rtot == 16'h0000);
   assign entry_ok    = (rsp_kind != nrti_pkg::KIND_SUMMARY) && (rsp_types == 14'h0000) &&
                        (rsp_names == 16'h0000) &&
                        ((rsp_kind != nrti_pkg::KIND_TYPE) || (rsp_tcode != 16'h0000));

   `NRTI_ASSERT_CLK(a_reset_idle, clock, reset |=> !rsp_valid, "record valid after reset")
   `NRTI_ASSERT_RST(a_valid_hold, clock, reset, rsp_stall |=> rsp_valid, "record dropped")
   `NRTI_ASSERT_RST(a_payload_hold, clock, reset, rsp_stall |=> $stable(rsp_payload), "moved")
   `NRTI_ASSERT_RST(a_summary_shape, clock, reset, (rsp_valid && rsp_final) |-> summary_ok, "bad summary")
   `NRTI_ASSERT_RST(a_entry_shape, clock, reset, (rsp_valid && !rsp_final) |-> entry_ok, "bad entry")

endmodule

bind ne_resource_table_indexer_top nrti_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_kind   (rsp_chan.record_kind),
   .rsp_offset (rsp_chan.entry_offset),
   .rsp_tcode  (rsp_chan.type_code),
   .rsp_rtot   (rsp_chan.resource_total),
   .rsp_types  (rsp_chan.type_entries_found),
   .rsp_names  (rsp_chan.names_found),
   .rsp_final  (rsp_chan.final_result)
);
